FILE: design/humidity_sensor_frame_decoder_assert.svh
// assertion macros for the humidity sensor frame decoder
// no dependencies; included by the top level only
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_ASSERT_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define HSFD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("hsfd assertion failed");
`define HSFD_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("hsfd forbidden condition");
`else
`define HSFD_ASSERT(lbl, prop)
`define HSFD_NEVER(lbl, cond)
`endif
`endif

FILE: design/hsfd_pkg.sv
// shared types, constants and the crc-8 byte step for the frame decoder
// no dependencies
package hsfd_pkg;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam int TEMP_SCALE = 17500;
	localparam int TEMP_OFFSET = 4500;
	localparam int HUM_SCALE = 10000;

	localparam logic KIND_MEAS = 1'b0;
	localparam logic KIND_ID = 1'b1;

	typedef struct packed {
		logic        kind;
		logic        err;
		logic [15:0] first_word;
		logic [15:0] second_word;
	} frame_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: design/humidity_sensor_frame_decoder.sv
// top level of the humidity sensor frame decoder
// depends on hsfd_pkg, hsfd_frame, hsfd_conv and the assertion macro header
//
// usage:
// slave stream takes one received sensor byte per item; tdata carries the
// start-of-frame flag and the byte, tuser the frame kind (sampled on a start
// byte only). a measurement frame is six bytes, an identifier frame three.
// master stream gives one item per completed frame: kind in tuser, crc status,
// temperature and humidity in centi-units and the identifier word in tdata.
// unused or failed fields read as zero.
// throughput: one byte per cycle while s_axis_tready is high, set by the
// byte-wide crc step in hsfd_frame. the result of a frame is registered in
// the frame register, then in the conversion register.
// reset: position to byte 0, crc to 0xff, error flag and kind cleared, both
// pipeline stages empty.
// stall: a held result fills the conversion register, then the frame register;
// s_axis_tready drops only when both are full, so no item is lost.
`include "humidity_sensor_frame_decoder_assert.svh"
module humidity_sensor_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [0] first_byte, [8:1] data_byte, rest zero
	input  logic        s_axis_tuser,  // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [0] status, [15:1] temperature_centi,
	                                   // [29:16] humidity_centi, [45:30] sensor_id
	output logic        m_axis_tuser   // [0] frame_kind
);

	logic             fr_valid;
	logic             fr_ready;
	hsfd_pkg::frame_t fr;
	logic             status;
	logic signed [14:0] temperature_centi;
	logic [13:0]      humidity_centi;
	logic [15:0]      sensor_id;

	hsfd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.kind      (s_axis_tuser),
		.first_byte(s_axis_tdata[0]),
		.data_byte (s_axis_tdata[8:1]),
		.res_valid (fr_valid),
		.res_ready (fr_ready),
		.res       (fr)
	);

	hsfd_conv u_conv (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (fr_valid),
		.in_ready         (fr_ready),
		.frame            (fr),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.frame_kind       (m_axis_tuser),
		.status           (status),
		.temperature_centi(temperature_centi),
		.humidity_centi   (humidity_centi),
		.sensor_id        (sensor_id)
	);

	assign m_axis_tdata = {2'b00, sensor_id, humidity_centi, temperature_centi, status};

	`HSFD_ASSERT(a_err_zero, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[45:1] == 45'd0)
	`HSFD_ASSERT(a_id_no_meas, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[29:1] == 29'd0)
	`HSFD_ASSERT(a_meas_no_id, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[45:30] == 16'd0)
	`HSFD_NEVER(a_full_stall, fr_valid && !fr_ready && s_axis_tready)

endmodule

FILE: design/hsfd_frame.sv
// byte framing and crc-8 check, one byte per cycle while in_ready is high
// depends on hsfd_pkg; hands a completed frame to the conversion stage
module hsfd_frame (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            kind,
	input  logic            first_byte,
	input  logic [7:0]      data_byte,
	output logic            res_valid,
	input  logic            res_ready,
	output hsfd_pkg::frame_t res
);

	typedef enum logic [2:0] {
		POS_W0_HI  = 3'd0,
		POS_W0_LO  = 3'd1,
		POS_W0_CRC = 3'd2,
		POS_W1_HI  = 3'd3,
		POS_W1_LO  = 3'd4,
		POS_W1_CRC = 3'd5
	} pos_t;

	pos_t        pos_q, pos_cur, pos_n;
	logic [7:0]  crc_q, crc_cur, crc_n;
	logic        err_q, err_cur, err_n;
	logic        kind_q, kind_cur;
	logic [15:0] fw_q, fw_n;
	logic [15:0] sw_q, sw_n;
	logic        done;
	logic        accept;
	logic        valid_s1;
	hsfd_pkg::frame_t res_s1;

	assign in_ready = !valid_s1 || res_ready;
	assign accept = in_valid && in_ready;

	always_comb begin
		pos_cur = first_byte ? POS_W0_HI : pos_q;
		crc_cur = first_byte ? hsfd_pkg::CRC_INIT : crc_q;
		err_cur = first_byte ? 1'b0 : err_q;
		kind_cur = first_byte ? kind : kind_q;
		crc_n = crc_cur;
		err_n = err_cur;
		fw_n = fw_q;
		sw_n = sw_q;
		done = 1'b0;
		unique case (pos_cur)
			POS_W0_HI: begin
				fw_n = {data_byte, fw_q[7:0]};
				crc_n = hsfd_pkg::crc8_step(crc_cur, data_byte);
			end
			POS_W0_LO: begin
				fw_n = {fw_q[15:8], data_byte};
				crc_n = hsfd_pkg::crc8_step(crc_cur, data_byte);
			end
			POS_W0_CRC: begin
				err_n = err_cur || (crc_cur != data_byte);
				crc_n = hsfd_pkg::CRC_INIT;
				done = (kind_cur == hsfd_pkg::KIND_ID);
			end
			POS_W1_HI: begin
				sw_n = {data_byte, sw_q[7:0]};
				crc_n = hsfd_pkg::crc8_step(crc_cur, data_byte);
			end
			POS_W1_LO: begin
				sw_n = {sw_q[15:8], data_byte};
				crc_n = hsfd_pkg::crc8_step(crc_cur, data_byte);
			end
			default: begin
				err_n = err_cur || (crc_cur != data_byte);
				done = 1'b1;
			end
		endcase
		pos_n = done ? POS_W0_HI : pos_t'(pos_cur + 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_W0_HI;
			crc_q <= hsfd_pkg::CRC_INIT;
			err_q <= 1'b0;
			kind_q <= hsfd_pkg::KIND_MEAS;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				pos_q <= pos_n;
				crc_q <= done ? hsfd_pkg::CRC_INIT : crc_n;
				err_q <= done ? 1'b0 : err_n;
				kind_q <= kind_cur;
			end
			valid_s1 <= (valid_s1 && !res_ready) || (accept && done);
		end
	end

	// words and the frame record carry no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			fw_q <= fw_n;
			sw_q <= sw_n;
			if (done) begin
				res_s1 <= '{kind: kind_cur, err: err_n, first_word: fw_n, second_word: sw_n};
			end
		end
	end

	assign res_valid = valid_s1;
	assign res = res_s1;

endmodule

FILE: design/hsfd_conv.sv
// converts raw words of a completed frame to centi-units into the result register
// depends on hsfd_pkg; divide by 65535 done as (x + (x >> 16) + 1) >> 16
module hsfd_conv (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hsfd_pkg::frame_t frame,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             frame_kind,
	output logic             status,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]      humidity_centi,
	output logic [15:0]      sensor_id
);

	logic [30:0] t_prod;
	logic [31:0] t_sum;
	logic [15:0] t_quo;
	logic [29:0] h_prod;
	logic [30:0] h_sum;
	logic [14:0] h_quo;
	logic signed [14:0] temp_n;
	logic [13:0] hum_n;
	logic [15:0] id_n;
	logic        valid_s2;
	logic        kind_s2, status_s2;
	logic signed [14:0] temp_s2;
	logic [13:0] hum_s2;
	logic [15:0] id_s2;

	assign in_ready = !valid_s2 || out_ready;

	always_comb begin
		t_prod = 31'(hsfd_pkg::TEMP_SCALE) * {15'd0, frame.first_word};
		t_sum = {1'b0, t_prod} + {17'd0, t_prod[30:16]} + 32'd1;
		t_quo = t_sum[31:16];
		h_prod = 30'(hsfd_pkg::HUM_SCALE) * {14'd0, frame.second_word};
		h_sum = {1'b0, h_prod} + {17'd0, h_prod[29:16]} + 31'd1;
		h_quo = h_sum[30:16];
		temp_n = '0;
		hum_n = '0;
		id_n = '0;
		if (!frame.err) begin
			if (frame.kind == hsfd_pkg::KIND_ID) begin
				id_n = frame.first_word;
			end else begin
				temp_n = $signed(t_quo[14:0]) - 15'(hsfd_pkg::TEMP_OFFSET);
				hum_n = h_quo[13:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s2 <= frame.kind;
			status_s2 <= frame.err;
			temp_s2 <= temp_n;
			hum_s2 <= hum_n;
			id_s2 <= id_n;
		end
	end

	assign out_valid = valid_s2;
	assign frame_kind = kind_s2;
	assign status = status_s2;
	assign temperature_centi = temp_s2;
	assign humidity_centi = hum_s2;
	assign sensor_id = id_s2;

endmodule
